// ===== rtl/bdpc_pkg.sv =====
// Package for the Bayer defect pixel correction block.
// Holds the shared constants, register codes and the threshold settings struct.
// No dependencies.
package bdpc_pkg;

  localparam int MAX_LINE_WIDTH_DEF = 4096;
  localparam int PIXEL_BITS_DEF     = 16;
  localparam int QUEUE_DEPTH        = 8;
  localparam int GAIN_SHIFT         = 8;

  localparam logic [1:0]  ENABLE_RESET       = 2'd3;
  localparam logic [12:0] LINE_WIDTH_RESET   = 13'd4096;
  localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd4096;

  typedef enum logic [2:0] {
    REG_BLACK_LEVEL = 3'd0,
    REG_HOT_BASE    = 3'd1,
    REG_COLD_BASE   = 3'd2,
    REG_HOT_GAIN    = 3'd3,
    REG_COLD_GAIN   = 3'd4,
    REG_ENABLE      = 3'd5,
    REG_LINE_WIDTH  = 3'd6,
    REG_FRAME_HGT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] black_level;
    logic [15:0] hot_base;
    logic [15:0] cold_base;
    logic [15:0] hot_gain;
    logic [15:0] cold_gain;
    logic [1:0]  enable;
  } thr_cfg_t;

endpackage

// ===== rtl/bdpc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module bdpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[waddr_i] <= wdata_i;
    end
    rdata_r <= mem_r[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== rtl/bdpc_cell.sv =====
// One column cell of the 3x5 neighbour window: holds three samples of a column
// and hands them to the next older cell on each shift. No dependencies.
module bdpc_cell #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                       clk,
  input  logic                       shift_i,
  input  logic [2:0][PIXEL_BITS-1:0] col_i,
  output logic [2:0][PIXEL_BITS-1:0] col_o
);

  logic [2:0][PIXEL_BITS-1:0] col_r;

  always_ff @(posedge clk) begin
    if (shift_i) begin
      col_r <= col_i;
    end
  end

  assign col_o = col_r;

endmodule

// ===== rtl/bdpc_correct.sv =====
// Two-stage correction unit: min and max of eight neighbours, level-dependent
// margins, then hot and cold clamping. Depends on bdpc_pkg.
module bdpc_correct #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                    clk,
  input  logic [PIXEL_BITS-1:0]   nb_i [8],
  input  logic [PIXEL_BITS-1:0]   y_i,
  input  bdpc_pkg::thr_cfg_t      thr_i,
  output logic [PIXEL_BITS-1:0]   pix_o
);

  logic [PIXEL_BITS-1:0] mx, mn;
  logic [16:0]           diff;
  logic                  ge;
  logic [31:0]           prod_hot, prod_cold;

  logic [PIXEL_BITS-1:0] mx_r, mn_r, y_r;
  logic                  ge_r;
  logic [31:0]           prod_hot_r, prod_cold_r;

  logic [24:0] hot, cold;
  logic [25:0] hot_lim, cold_sum;
  logic [PIXEL_BITS-1:0] y_hot;

  always_comb begin
    mx = nb_i[0];
    mn = nb_i[0];
    for (int k = 1; k < 8; k++) begin
      if (nb_i[k] > mx) mx = nb_i[k];
      if (nb_i[k] < mn) mn = nb_i[k];
    end
    ge        = 17'(y_i) >= {1'b0, thr_i.black_level};
    diff      = 17'(y_i) - {1'b0, thr_i.black_level};
    prod_hot  = diff[15:0] * thr_i.hot_gain;
    prod_cold = diff[15:0] * thr_i.cold_gain;
  end

  always_ff @(posedge clk) begin
    mx_r        <= mx;
    mn_r        <= mn;
    y_r         <= y_i;
    ge_r        <= ge;
    prod_hot_r  <= prod_hot;
    prod_cold_r <= prod_cold;
  end

  always_comb begin
    hot  = 25'(thr_i.hot_base);
    cold = 25'(thr_i.cold_base);
    if (ge_r) begin
      hot  = hot + 25'(prod_hot_r[31:bdpc_pkg::GAIN_SHIFT]);
      cold = cold + 25'(prod_cold_r[31:bdpc_pkg::GAIN_SHIFT]);
    end
    hot_lim = 26'(mx_r) + 26'(hot);
    y_hot   = (thr_i.enable[0] && 26'(y_r) > hot_lim) ? mx_r : y_r;
    cold_sum = 26'(y_hot) + 26'(cold);
    pix_o   = (thr_i.enable[1] && cold_sum < 26'(mn_r)) ? mn_r : y_hot;
  end

endmodule

// ===== rtl/bayer_defect_pixel_correction.sv =====
// Bayer defect pixel correction top level: line stores, window cell chain,
// three correction lanes and a result queue. Depends on bdpc_pkg, bdpc_ram,
// bdpc_cell and bdpc_correct.
// Throughput is one request per cycle while the result queue has room. A line end
// request that emits carries three results, which the eight-entry result queue drains
// at one per cycle while out_tready is high. Reset clears control state and the
// config registers only; the line stores are not cleared and need no clearing pass.
module bayer_defect_pixel_correction #(
  parameter int MAX_LINE_WIDTH = bdpc_pkg::MAX_LINE_WIDTH_DEF,
  parameter int PIXEL_BITS     = bdpc_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel_value
  input  logic [0:0]  in_tuser,   // [0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] corrected_pixel
  output logic [1:0]  out_tuser,  // [0] end_of_line, [1] end_of_frame
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW  = $clog2(MAX_LINE_WIDTH);
  localparam int QD  = bdpc_pkg::QUEUE_DEPTH;
  localparam int QAW = $clog2(QD);

  typedef struct packed {
    logic       valid;
    logic       drain;
    logic       has_a;
    logic       has_bc;
    logic       cc_small;
    logic       eof;
    logic       top_is_p;
    logic [1:0] top_slot;
    logic [1:0] mid_slot;
  } stage_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pa;
    logic [PIXEL_BITS-1:0] pb;
    logic [PIXEL_BITS-1:0] pc;
    logic                  has_a;
    logic                  has_bc;
    logic                  eof;
  } qent_t;

  // Configuration registers.
  bdpc_pkg::thr_cfg_t thr_r;
  logic [12:0]        line_width_r;
  logic [15:0]        frame_height_r;
  logic               cfg_wr;
  bdpc_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = bdpc_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r          <= '0;
      thr_r.enable   <= bdpc_pkg::ENABLE_RESET;
      line_width_r   <= bdpc_pkg::LINE_WIDTH_RESET;
      frame_height_r <= bdpc_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bdpc_pkg::REG_BLACK_LEVEL: thr_r.black_level <= cfg_pwdata[15:0];
        bdpc_pkg::REG_HOT_BASE:    thr_r.hot_base    <= cfg_pwdata[15:0];
        bdpc_pkg::REG_COLD_BASE:   thr_r.cold_base   <= cfg_pwdata[15:0];
        bdpc_pkg::REG_HOT_GAIN:    thr_r.hot_gain    <= cfg_pwdata[15:0];
        bdpc_pkg::REG_COLD_GAIN:   thr_r.cold_gain   <= cfg_pwdata[15:0];
        bdpc_pkg::REG_ENABLE:      thr_r.enable      <= cfg_pwdata[1:0];
        bdpc_pkg::REG_LINE_WIDTH:  line_width_r      <= cfg_pwdata[12:0];
        bdpc_pkg::REG_FRAME_HGT:   frame_height_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bdpc_pkg::REG_BLACK_LEVEL: cfg_prdata = {16'd0, thr_r.black_level};
      bdpc_pkg::REG_HOT_BASE:    cfg_prdata = {16'd0, thr_r.hot_base};
      bdpc_pkg::REG_COLD_BASE:   cfg_prdata = {16'd0, thr_r.cold_base};
      bdpc_pkg::REG_HOT_GAIN:    cfg_prdata = {16'd0, thr_r.hot_gain};
      bdpc_pkg::REG_COLD_GAIN:   cfg_prdata = {16'd0, thr_r.cold_gain};
      bdpc_pkg::REG_ENABLE:      cfg_prdata = {30'd0, thr_r.enable};
      bdpc_pkg::REG_LINE_WIDTH:  cfg_prdata = {19'd0, line_width_r};
      bdpc_pkg::REG_FRAME_HGT:   cfg_prdata = {16'd0, frame_height_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  // Position tracking and line store access.
  logic [CW-1:0]         col_r, col_nxt, cc, w_m1;
  logic [15:0]           row_r, row_nxt, row_inc, h_eff;
  logic                  drain_r, drain_nxt;
  logic [14:0]           lw_ext, w_eff;
  logic                  in_fire, act, line_end, emit;
  logic [PIXEL_BITS-1:0] p_in;
  logic [1:0]            top_slot;
  stage_t                s0, s1_r, s2_r, s3_r;
  logic [PIXEL_BITS-1:0] p1_r;

  assign lw_ext = {2'd0, line_width_r};
  assign w_eff  = (lw_ext < 15'd4) ? 15'd4 :
                  (lw_ext > 15'(MAX_LINE_WIDTH)) ? 15'(MAX_LINE_WIDTH) : lw_ext;
  assign w_m1   = CW'(w_eff - 15'd1);
  assign h_eff  = (frame_height_r < 16'd4) ? 16'd4 : frame_height_r;
  assign cc     = (col_r > w_m1) ? w_m1 : col_r;
  assign line_end = (cc == w_m1);
  assign p_in   = in_tdata[PIXEL_BITS-1:0];
  assign in_fire = in_tvalid && in_tready;
  assign act    = in_fire && (drain_r || !in_tuser[0]);
  assign emit   = drain_r || (row_r >= 16'd2);
  assign row_inc = row_r + 16'd1;
  assign top_slot = drain_r ? (h_eff[1:0] + {1'b0, row_r[0]}) : row_r[1:0];

  always_comb begin
    s0.valid    = act;
    s0.drain    = drain_r;
    s0.has_a    = emit && (cc >= CW'(2));
    s0.has_bc   = emit && line_end;
    s0.cc_small = (cc < CW'(4));
    s0.eof      = drain_r && row_r[0];
    s0.top_is_p = !drain_r && (row_r < 16'd4);
    s0.top_slot = top_slot;
    s0.mid_slot = top_slot + 2'd2;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    if (act) begin
      if (line_end) begin
        col_nxt = '0;
        if (!drain_r) begin
          if (row_inc >= h_eff || row_inc == 16'd0) begin
            drain_nxt = 1'b1;
            row_nxt   = 16'd0;
          end else begin
            row_nxt = row_inc;
          end
        end else if (!row_r[0]) begin
          row_nxt = 16'd1;
        end else begin
          drain_nxt = 1'b0;
          row_nxt   = 16'd0;
        end
      end else begin
        col_nxt = cc + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= 1'b0;
      s1_r    <= '0;
      s2_r    <= '0;
      s3_r    <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      s1_r    <= s0;
      s2_r    <= s1_r;
      s3_r    <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= p_in;
  end

  logic [PIXEL_BITS-1:0] ram_q [4];

  for (genvar g = 0; g < 4; g++) begin : g_line
    bdpc_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_LINE_WIDTH)
    ) u_ram (
      .clk     (clk),
      .we_i    (act && !drain_r && (row_r[1:0] == 2'(g))),
      .waddr_i (cc),
      .wdata_i (p_in),
      .raddr_i (cc),
      .rdata_o (ram_q[g])
    );
  end

  // Window cell chain: cell 4 takes the newest column.
  logic [PIXEL_BITS-1:0]      top1, mid1, bot1;
  logic [2:0][PIXEL_BITS-1:0] win [5];

  assign top1 = s1_r.top_is_p ? p1_r : ram_q[s1_r.top_slot];
  assign mid1 = ram_q[s1_r.mid_slot];
  assign bot1 = s1_r.drain ? top1 : p1_r;

  for (genvar j = 0; j < 5; j++) begin : g_cell
    if (j == 4) begin : g_head
      bdpc_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk     (clk),
        .shift_i (s1_r.valid),
        .col_i   ({bot1, mid1, top1}),
        .col_o   (win[j])
      );
    end else begin : g_body
      bdpc_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell (
        .clk     (clk),
        .shift_i (s1_r.valid),
        .col_i   (win[j+1]),
        .col_o   (win[j])
      );
    end
  end

  // Correction lanes: A for column cc-2, B and C for the two last columns.
  logic [PIXEL_BITS-1:0] nb_a [8], nb_b [8], nb_c [8];
  logic [PIXEL_BITS-1:0] lo_a [3];
  logic [PIXEL_BITS-1:0] pix_a, pix_b, pix_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_a[i] = s2_r.cc_small ? win[4][i] : win[0][i];
    end
    nb_a = '{lo_a[0], win[2][0], win[4][0], lo_a[1], win[4][1],
             lo_a[2], win[2][2], win[4][2]};
    nb_b = '{win[1][0], win[3][0], win[1][0], win[1][1], win[1][1],
             win[1][2], win[3][2], win[1][2]};
    nb_c = '{win[2][0], win[4][0], win[2][0], win[2][1], win[2][1],
             win[2][2], win[4][2], win[2][2]};
  end

  bdpc_correct #(.PIXEL_BITS(PIXEL_BITS)) u_corr_a (
    .clk (clk), .nb_i (nb_a), .y_i (win[2][1]), .thr_i (thr_r), .pix_o (pix_a)
  );
  bdpc_correct #(.PIXEL_BITS(PIXEL_BITS)) u_corr_b (
    .clk (clk), .nb_i (nb_b), .y_i (win[3][1]), .thr_i (thr_r), .pix_o (pix_b)
  );
  bdpc_correct #(.PIXEL_BITS(PIXEL_BITS)) u_corr_c (
    .clk (clk), .nb_i (nb_c), .y_i (win[4][1]), .thr_i (thr_r), .pix_o (pix_c)
  );

  // Result queue, one entry per request with results.
  qent_t            q_mem_r [QD];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     q_cnt_r;
  logic [1:0]       sub_r, pos;
  logic             push, pop_res, pop_ent, out_last;
  logic [1:0]       inflight;
  logic [QAW+1:0]   occupancy;
  qent_t            head;

  assign push = s3_r.valid && (s3_r.has_a || s3_r.has_bc);
  assign inflight = 2'(s1_r.valid && (s1_r.has_a || s1_r.has_bc))
                  + 2'(s2_r.valid && (s2_r.has_a || s2_r.has_bc))
                  + 2'(push);
  assign occupancy = (QAW+2)'(q_cnt_r) + (QAW+2)'(inflight);
  assign in_tready = occupancy < (QAW+2)'(QD);

  assign head       = q_mem_r[rd_ptr_r];
  assign pos        = sub_r + (head.has_a ? 2'd0 : 2'd1);
  assign out_last   = head.has_bc ? (pos == 2'd2) : 1'b1;
  assign out_tvalid = (q_cnt_r != '0);
  assign pop_res    = out_tvalid && out_tready;
  assign pop_ent    = pop_res && out_last;

  always_comb begin
    case (pos)
      2'd0:    out_tdata = 16'(head.pa);
      2'd1:    out_tdata = 16'(head.pb);
      default: out_tdata = 16'(head.pc);
    endcase
    out_tuser[0] = head.has_bc && (pos == 2'd2);
    out_tuser[1] = head.has_bc && (pos == 2'd2) && head.eof;
    out_tlast    = out_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{pa: pix_a, pb: pix_b, pc: pix_c, has_a: s3_r.has_a,
                             has_bc: s3_r.has_bc, eof: s3_r.eof};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      sub_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QD-1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop_ent) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QD-1)) ? '0 : rd_ptr_r + QAW'(1);
        sub_r    <= '0;
      end else if (pop_res) begin
        sub_r <= sub_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + (QAW+1)'(push) - (QAW+1)'(pop_ent);
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (QAW+1)'(QD))
    else $error("result queue overflow");

  a_eof_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tuser[0] && out_tlast))
    else $error("end of frame without end of line");

  a_drain_rows: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (row_r <= 16'd1))
    else $error("drain row counter out of range");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (q_cnt_r != '0))
    else $error("queue empty after push");
`endif

endmodule

// ===== test/bdpc_scoreboard.sv =====
// Checker for the Bayer defect pixel correction block: watches the request,
// result and register ports, predicts each corrected pixel and compares it.
// Depends on bdpc_pkg for register codes, reset values and the gain shift.
module bdpc_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending,
  output int          pixels_seen
);

  localparam int STORE_W = 4096;

  typedef struct packed {
    logic [15:0] pix;
    logic        eol;
    logic        eof;
    logic        last;
  } pix_result_t;

  pix_result_t expected_pixels[$];

  logic [15:0] black, hot_base, cold_base, hot_gain, cold_gain;
  logic [1:0]  enable;
  logic [12:0] width_reg;
  logic [15:0] height_reg;

  logic [15:0] line_mem [4*STORE_W];
  logic [15:0] window [3][5];
  int unsigned col_pos, row_pos;
  bit          draining;

  function automatic int unsigned slot(int unsigned a, int unsigned cc);
    int i;
    i = int'(a) + 4 - int'(cc);
    if (i < 0) i = 0;
    if (i > 4) i = 4;
    return i;
  endfunction

  function automatic logic [15:0] clamp_pixel(int unsigned x, int unsigned cc,
                                              int unsigned w);
    int unsigned lo, hi, il, im, ih;
    logic [15:0] nb [8];
    logic [15:0] mx, mn;
    logic [63:0] y, hot, cold;
    lo = (x < 2) ? x + 2 : x - 2;
    hi = (x + 2 >= w) ? x - 2 : x + 2;
    il = slot(lo, cc);
    im = slot(x, cc);
    ih = slot(hi, cc);
    nb[0] = window[0][il]; nb[1] = window[0][im]; nb[2] = window[0][ih];
    nb[3] = window[1][il]; nb[4] = window[1][ih];
    nb[5] = window[2][il]; nb[6] = window[2][im]; nb[7] = window[2][ih];
    mx = nb[0];
    mn = nb[0];
    for (int k = 1; k < 8; k++) begin
      if (nb[k] > mx) mx = nb[k];
      if (nb[k] < mn) mn = nb[k];
    end
    y = window[1][im];
    hot = hot_base;
    cold = cold_base;
    if (y >= black) begin
      hot += ((y - black) * hot_gain) >> bdpc_pkg::GAIN_SHIFT;
      cold += ((y - black) * cold_gain) >> bdpc_pkg::GAIN_SHIFT;
    end
    if (enable[0] && y > 64'(mx) + hot) y = mx;
    if (enable[1] && y + cold < 64'(mn)) y = mn;
    return y[15:0];
  endfunction

  function automatic void predict_pixels(bit flush, logic [15:0] p);
    int unsigned w, h, cc, r, y, nx;
    logic [15:0] top, mid, bot;
    int unsigned xs [3];
    bit emit;
    pix_result_t res;
    w = width_reg < 4 ? 4 : (width_reg > STORE_W ? STORE_W : width_reg);
    h = height_reg < 4 ? 4 : height_reg;
    cc = col_pos > w - 1 ? w - 1 : col_pos;
    y = 0;
    nx = 0;
    if (!draining && flush) return;
    if (!draining) begin
      r = row_pos;
      top = (r < 4) ? p : line_mem[(r & 3) * STORE_W + cc];
      mid = line_mem[((r + 2) & 3) * STORE_W + cc];
      bot = p;
      line_mem[(r & 3) * STORE_W + cc] = p;
      emit = r >= 2;
      if (emit) y = r - 2;
    end else begin
      r = h + (row_pos & 1);
      top = line_mem[(r & 3) * STORE_W + cc];
      mid = line_mem[((r + 2) & 3) * STORE_W + cc];
      bot = top;
      emit = 1;
      y = r - 2;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 4; j++)
        window[i][j] = window[i][j+1];
    window[0][4] = top;
    window[1][4] = mid;
    window[2][4] = bot;
    if (emit) begin
      if (cc >= 2) xs[nx++] = cc - 2;
      if (cc == w - 1) begin
        xs[nx++] = w - 2;
        xs[nx++] = w - 1;
      end
      for (int i = 0; i < nx; i++) begin
        res.pix  = clamp_pixel(xs[i], cc, w);
        res.eol  = xs[i] == w - 1;
        res.eof  = xs[i] == w - 1 && draining && y == h - 1;
        res.last = i + 1 == nx;
        expected_pixels.push_back(res);
      end
    end
    if (cc >= w - 1) begin
      col_pos = 0;
      if (!draining) begin
        row_pos = (row_pos + 1) & 16'hFFFF;
        if (row_pos >= h || row_pos == 0) begin
          draining = 1;
          row_pos = 0;
        end
      end else if (row_pos == 0) begin
        row_pos = 1;
      end else begin
        draining = 0;
        row_pos = 0;
      end
    end else begin
      col_pos = cc + 1;
    end
  endfunction

  always @(posedge clk) begin
    pix_result_t want;
    if (!rst_n) begin
      black <= '0; hot_base <= '0; cold_base <= '0;
      hot_gain <= '0; cold_gain <= '0;
      enable <= bdpc_pkg::ENABLE_RESET;
      width_reg <= bdpc_pkg::LINE_WIDTH_RESET;
      height_reg <= bdpc_pkg::FRAME_HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      draining = 0;
      mismatches = 0;
      pixels_seen = 0;
      expected_pixels.delete();
      for (int i = 0; i < 4*STORE_W; i++) line_mem[i] = '0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 5; j++)
          window[i][j] = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (bdpc_pkg::reg_idx_t'(cfg_paddr[4:2]))
          bdpc_pkg::REG_BLACK_LEVEL: black      <= cfg_pwdata[15:0];
          bdpc_pkg::REG_HOT_BASE:    hot_base   <= cfg_pwdata[15:0];
          bdpc_pkg::REG_COLD_BASE:   cold_base  <= cfg_pwdata[15:0];
          bdpc_pkg::REG_HOT_GAIN:    hot_gain   <= cfg_pwdata[15:0];
          bdpc_pkg::REG_COLD_GAIN:   cold_gain  <= cfg_pwdata[15:0];
          bdpc_pkg::REG_ENABLE:      enable     <= cfg_pwdata[1:0];
          bdpc_pkg::REG_LINE_WIDTH:  width_reg  <= cfg_pwdata[12:0];
          bdpc_pkg::REG_FRAME_HGT:   height_reg <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_pixels(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: pixel %h eol %b eof %b last %b",
                     out_tdata, out_tuser[0], out_tuser[1], out_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.pix !== out_tdata || want.eol !== out_tuser[0] ||
              want.eof !== out_tuser[1] || want.last !== out_tlast) begin
            if (mismatches < 10)
              $display("result mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                       want.pix, want.eol, want.eof, want.last,
                       out_tdata, out_tuser[0], out_tuser[1], out_tlast);
            mismatches++;
          end
        end
      end
    end
    pending = expected_pixels.size();
  end
endmodule

// ===== test/tb_top.sv =====
// Top of the defect pixel correction testbench: clock, reset, register writes,
// pixel frames with random gaps and result stalls, and the final verdict.
// Depends on bdpc_pkg, bdpc_scoreboard and the bayer_defect_pixel_correction RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches, pending, pixels_seen;
  int cycles = 0;
  int requests = 0;
  int frames = 0;
  bit calm = 0;

  always #1 clk = ~clk;

  bayer_defect_pixel_correction uut (.*);

  bdpc_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bayer_defect_pixel_correction test failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic reg_write(bdpc_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  task automatic send(bit flush, logic [15:0] value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= flush;
    in_tdata <= value;
    do @(posedge clk); while (!in_tready);
    requests++;
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] scene_value(logic [15:0] base);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'hFFFF;
    if (pick == 1) return 16'h0000;
    if (pick < 4) return $urandom_range(0, 65535);
    return base + $urandom_range(0, 64);
  endfunction

  task automatic random_frame();
    int w, h;
    logic [15:0] base;
    w = $urandom_range(4, 8);
    h = $urandom_range(4, 6);
    if ($urandom_range(0, 3) == 0) begin
      reg_write(bdpc_pkg::REG_LINE_WIDTH, $urandom_range(0, 3));
      w = 4;
    end else begin
      reg_write(bdpc_pkg::REG_LINE_WIDTH, w);
    end
    if ($urandom_range(0, 3) == 0) begin
      reg_write(bdpc_pkg::REG_FRAME_HGT, $urandom_range(0, 3));
      h = 4;
    end else begin
      reg_write(bdpc_pkg::REG_FRAME_HGT, h);
    end
    reg_write(bdpc_pkg::REG_BLACK_LEVEL,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 512));
    reg_write(bdpc_pkg::REG_HOT_BASE, $urandom_range(0, 300));
    reg_write(bdpc_pkg::REG_COLD_BASE, $urandom_range(0, 300));
    reg_write(bdpc_pkg::REG_HOT_GAIN,
              $urandom_range(0, 4) == 0 ? 16'hFFFF : $urandom_range(0, 64));
    reg_write(bdpc_pkg::REG_COLD_GAIN,
              $urandom_range(0, 4) == 0 ? 16'hFFFF : $urandom_range(0, 64));
    reg_write(bdpc_pkg::REG_ENABLE, $urandom_range(0, 3));
    calm = $urandom_range(0, 3) == 0;
    base = $urandom_range(0, 65000);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 14) == 0) send(1, $urandom_range(0, 65535));
      send(0, scene_value(base));
    end
    for (int i = 0; i < 2 * w; i++)
      send($urandom_range(0, 4) != 0, $urandom_range(0, 65535));
    frames++;
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    reg_write(bdpc_pkg::REG_LINE_WIDTH, 4);
    reg_write(bdpc_pkg::REG_FRAME_HGT, 4);
    reg_write(bdpc_pkg::REG_BLACK_LEVEL, 0);
    reg_write(bdpc_pkg::REG_HOT_BASE, 0);
    reg_write(bdpc_pkg::REG_COLD_BASE, 0);
    reg_write(bdpc_pkg::REG_HOT_GAIN, 0);
    reg_write(bdpc_pkg::REG_COLD_GAIN, 0);
    reg_write(bdpc_pkg::REG_ENABLE, 3);
    // A flush outside the drain is dropped; then one frame with full-scale spikes.
    send(1, 16'h1234);
    for (int i = 0; i < 16; i++)
      send(0, (i == 5) ? 16'hFFFF : (i == 10) ? 16'h0000 : 16'h8000 + i);
    send(0, 16'hFFFF);
    for (int i = 0; i < 7; i++) send(1, 16'h0000);
    frames++;
    settle();
    reg_write(bdpc_pkg::REG_BLACK_LEVEL, 16'hFFFF);
    reg_write(bdpc_pkg::REG_HOT_BASE, 16'hFFFF);
    reg_write(bdpc_pkg::REG_COLD_BASE, 16'hFFFF);
    reg_write(bdpc_pkg::REG_HOT_GAIN, 16'hFFFF);
    reg_write(bdpc_pkg::REG_COLD_GAIN, 16'hFFFF);
    reg_write(bdpc_pkg::REG_ENABLE, 0);
    while (requests < 180) random_frame();
    settle();
    $display("Sent %0d requests over %0d frames and checked %0d corrected pixels.",
             requests, frames, pixels_seen);
    if (mismatches == 0) begin
      $display("bayer_defect_pixel_correction test passed");
    end else begin
      $display("bayer_defect_pixel_correction test failed");
    end
    $finish;
  end
endmodule
